>>> hw/rtl/frame_difference_motion_detector_core_assert.svh
// Assertion macros used by the motion detector checker.
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define FDMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("motion detector check failed");

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define FDMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("motion detector check failed");

`endif

>>> hw/rtl/fdmd_pkg.sv
// Shared types and constants of the frame difference motion detector.
`default_nettype none

package fdmd_pkg;

    // Frame store size in pixels.
    localparam int unsigned MAX_PIXELS = 2097152;
    localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned TICK_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};

    // Register reset values.
    localparam logic [PIX_W-1:0]   THRESHOLD_RST = 8'd20;
    localparam logic [COUNT_W-1:0] LIMIT_RST     = 22'd4608;
    localparam logic [TICK_W-1:0]  HOLD_RST      = 16'd1300;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGED_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 2'd2;

    // Request kinds carried on tuser.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Output word layout, lowest bit first.
    localparam int unsigned OUT_W = 24;

    // Item after the frame store read is issued.
    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] gray;
        logic             last;
        logic             first;
    } rd_stage_t;

    // Item after the pixel compare.
    typedef struct packed {
        logic req_type;
        logic changed;
        logic last;
    } cnt_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/frame_difference_motion_detector_core.sv
// Frame difference motion detector: frame store, change counter and movement flag.
`default_nettype none

// Takes one word per cycle on the s_ side unless stalled: a gray pixel in raster order
// (tuser = 0, tlast on the final pixel of the frame) or a one-millisecond tick (tuser = 1).
// Each pixel is compared with the same position of the previous frame, kept in an
// on-chip frame store of MAX_PIXELS bytes (single port, read-before-write, one
// access per pixel); during the first frame after reset pixels compare against
// zero. The store is never cleared: a frame longer than every earlier frame reads
// stale contents beyond the old length. Pixels whose absolute difference exceeds
// diff_threshold are counted (saturating). On the last pixel of a frame one result
// word leaves on the m_ side: count above changed_limit sets the movement flag and
// restarts the hold timer, otherwise the flag clears once more than hold_ticks ticks
// have passed. Throughput is one word per cycle, ticks included, while no result
// stalls; a result passes the store read, compare and count stages in turn.
// A result that waits on m_tready stalls the pipeline only once the next last pixel
// reaches the count stage. Configuration writes take effect at once and belong in
// idle periods. No clearing pass runs after reset.
module frame_difference_motion_detector_core
    import fdmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] gray_pixel
    input  wire logic                 s_tlast,   // last_of_frame
    input  wire logic                 s_tuser,   // [0] req_type
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // [0] moving, [22:1] changed_count,
                                                 // [23] movement_seen
);

    // configuration registers
    logic [PIX_W-1:0]   threshold_reg, threshold_next;
    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic [TICK_W-1:0]  hold_reg, hold_next;

    // front end: address counter and first-frame marker
    logic [ADDR_W-1:0]  pixel_addr_reg, pixel_addr_next;
    logic               first_frame_reg, first_frame_next;

    // frame store and its registered read data
    logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];
    logic [PIX_W-1:0]   old_pixel_reg;

    // pipeline stages
    logic               rd_valid_reg, rd_valid_next;
    rd_stage_t          rd_reg, rd_next;
    logic               cnt_valid_reg, cnt_valid_next;
    cnt_stage_t         cnt_reg, cnt_next;

    // frame state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic               moving_reg, moving_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // handshake and datapath helpers
    logic               out_free;
    logic               cnt_done;
    logic               cnt_retire;
    logic               cnt_result;
    logic               rd_load;
    logic               in_fire;
    logic               in_pixel;
    logic [PIX_W-1:0]   old_pixel;
    logic [PIX_W-1:0]   abs_diff;
    logic [COUNT_W-1:0] count_inc;
    logic               seen;

    // Pipeline flow: the count stage stalls only on a last pixel facing a full output.
    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        cnt_result = cnt_valid_reg && (cnt_reg.req_type == REQ_PIXEL) && cnt_reg.last;
        cnt_done   = !cnt_result || out_free;
        cnt_retire = cnt_valid_reg && cnt_done;
        rd_load    = !rd_valid_reg || cnt_done;
        s_tready   = rd_load;
        in_fire    = s_tvalid && rd_load;
        in_pixel   = in_fire && (s_tuser == REQ_PIXEL);
    end

    // Frame store: read the old pixel and write the new one at the same address.
    always_ff @(posedge aclk) begin
        if (in_pixel) begin
            old_pixel_reg <= frame_mem[pixel_addr_reg];
            frame_mem[pixel_addr_reg] <= s_tdata;
        end
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_comb begin
        threshold_next = threshold_reg;
        limit_next     = limit_reg;
        hold_next      = hold_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_DIFF_THRESHOLD: threshold_next = cfg_wdata[PIX_W-1:0];
                REG_CHANGED_LIMIT:  limit_next     = cfg_wdata;
                REG_HOLD_TICKS:     hold_next      = cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: advance the address, drop the first-frame marker after its last pixel.
    always_comb begin
        pixel_addr_next  = pixel_addr_reg;
        first_frame_next = first_frame_reg;
        rd_valid_next    = rd_load ? in_fire : rd_valid_reg;
        rd_next          = rd_reg;
        if (in_fire) begin
            rd_next.req_type = s_tuser;
            rd_next.gray     = s_tdata;
            rd_next.last     = s_tlast;
            rd_next.first    = first_frame_reg;
        end
        if (in_pixel) begin
            if (s_tlast) begin
                pixel_addr_next  = '0;
                first_frame_next = 1'b0;
            end else if (pixel_addr_reg == LAST_ADDR) begin
                pixel_addr_next = '0;
            end else begin
                pixel_addr_next = pixel_addr_reg + 1'b1;
            end
        end
    end

    // Compare stage: first frame compares against zero.
    always_comb begin
        old_pixel      = rd_reg.first ? '0 : old_pixel_reg;
        abs_diff       = (rd_reg.gray > old_pixel) ? rd_reg.gray - old_pixel
                                                   : old_pixel - rd_reg.gray;
        cnt_valid_next = cnt_done ? rd_valid_reg : cnt_valid_reg;
        cnt_next       = cnt_reg;
        if (cnt_done && rd_valid_reg) begin
            cnt_next.req_type = rd_reg.req_type;
            cnt_next.changed  = abs_diff > threshold_reg;
            cnt_next.last     = rd_reg.last;
        end
    end

    // Count stage: saturating count, tick timer, movement decision at frame end.
    always_comb begin
        count_inc      = (cnt_reg.changed && (count_reg != COUNT_MAX)) ? count_reg + 1'b1
                                                                       : count_reg;
        seen           = count_inc > limit_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        moving_next    = moving_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        if (cnt_retire) begin
            if (cnt_reg.req_type == REQ_TICK) begin
                if (elapsed_reg != TICK_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end else if (!cnt_reg.last) begin
                count_next = count_inc;
            end else begin
                count_next = '0;
                if (seen) begin
                    moving_next  = 1'b1;
                    elapsed_next = '0;
                end else if (elapsed_reg > hold_reg) begin
                    moving_next = 1'b0;
                end
                out_valid_next = 1'b1;
                out_data_next  = {seen, count_inc, moving_next};
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RST;
            limit_reg       <= LIMIT_RST;
            hold_reg        <= HOLD_RST;
            pixel_addr_reg  <= '0;
            first_frame_reg <= 1'b1;
            rd_valid_reg    <= 1'b0;
            cnt_valid_reg   <= 1'b0;
            count_reg       <= '0;
            elapsed_reg     <= '0;
            moving_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            threshold_reg   <= threshold_next;
            limit_reg       <= limit_next;
            hold_reg        <= hold_next;
            pixel_addr_reg  <= pixel_addr_next;
            first_frame_reg <= first_frame_next;
            rd_valid_reg    <= rd_valid_next;
            cnt_valid_reg   <= cnt_valid_next;
            count_reg       <= count_next;
            elapsed_reg     <= elapsed_next;
            moving_reg      <= moving_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        rd_reg       <= rd_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fdmd_checker.sv
// Port-level checks of the frame difference motion detector, bound to the top level.
`default_nettype none

`include "frame_difference_motion_detector_core_assert.svh"

module fdmd_checker
    import fdmd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_W-1:0]     m_tdata
);

    // A stalled result word holds.
    `FDMD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Movement seen in this frame always leaves the flag set.
    `FDMD_ASSERT_NOW(a_seen_sets_flag, m_tvalid && m_tdata[COUNT_W+1], m_tdata[0])

    // A count above the limit cannot be zero.
    `FDMD_ASSERT_NOW(a_seen_nonzero, m_tvalid && m_tdata[COUNT_W+1], m_tdata[COUNT_W:1] != '0)

    // Input backpressure only comes from a result word blocked at the output.
    `FDMD_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

endmodule

bind frame_difference_motion_detector_core fdmd_checker u_fdmd_checker (.*);

`default_nettype wire
